>>> sv/xzis_pkg.sv
// Shared types and constants for the XZ index size summer.
package xzis_pkg;

    localparam int MAX_VARINT_BYTES = 9;
    localparam int GROUP_BITS       = 7;
    localparam int VARINT_GROUPS    = 9;
    localparam int VALUE_W          = 63;
    localparam int TOTAL_W          = 64;
    localparam int LEN_W            = 4;
    localparam int BYTE_W           = 8;
    localparam int STATUS_W         = 2;
    localparam int M_TDATA_W        = 128;

    localparam logic [BYTE_W-1:0] INDICATOR_BYTE = 8'h00;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_COUNT  = 3'd1,
        PH_UNPAD  = 3'd2,
        PH_UNCOMP = 3'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_IND = 2'd1,
        ST_LONG    = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] index_byte;
        logic              first_byte;
        logic              last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_uncompressed;
        logic [VALUE_W-1:0] records_done;
        status_t            status;
    } result_t;

endpackage

>>> sv/xz_index_size_summer_top.sv
// Top level of the XZ index size summer: input register, parser and result register.
//
//  Channel | Ports                        | Contents
//  --------+------------------------------+-----------------------------------------------
//  in      | s_tvalid s_tready s_tdata    | one index byte a beat; tuser marks the first
//          | s_tuser s_tlast              | byte, tlast the last byte of the section
//  out     | m_tvalid m_tready m_tdata    | one beat per section: total and record count,
//          | m_tuser                      | with the status code in tuser
//
// One byte is taken each cycle while no result is stalled; a byte's result, if it has one,
// comes out through the input register and then the result register around the parser.
// The parser's state update (a 64-bit add beside the varint merge) is the only loop.
// Reset is synchronous and active low; it empties both registers and idles the parser.
// A stalled result holds the pipeline, but an empty input register still takes a beat.
module xz_index_size_summer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [xzis_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] index_byte
    input  logic                           s_tuser,   // [0] first_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [xzis_pkg::M_TDATA_W-1:0] m_tdata,   // [63:0] total_uncompressed,
                                                      // [126:64] records_done, [127] zero
    output logic [xzis_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);
    import xzis_pkg::*;

    logic     in_valid_reg;
    in_beat_t in_beat_reg;
    logic     out_valid_reg;
    result_t  out_result_reg;
    logic     advance;
    logic     step;
    logic     emit;
    result_t  result;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_beat_reg.index_byte <= s_tdata;
            in_beat_reg.first_byte <= s_tuser;
            in_beat_reg.last_byte  <= s_tlast;
        end
    end

    xzis_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .beat    (in_beat_reg),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_result_reg.records_done, out_result_reg.total_uncompressed};
    assign m_tuser  = out_result_reg.status;

    a_step_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> advance)
        else $error("result produced with the result register blocked");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> !$past(step))
        else $error("byte parsed while a result was stalled");

    a_in_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_beat_reg))
        else $error("held input beat lost during a stall");

endmodule

>>> sv/xzis_parser.sv
// Byte-at-a-time index parser: varint decoding, record counting and size summing.
module xzis_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  xzis_pkg::in_beat_t beat,
    output logic              emit,
    output xzis_pkg::result_t result
);
    import xzis_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [VALUE_W-1:0] left_reg, left_next;
    logic [VALUE_W-1:0] seen_reg, seen_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    status_t            status_c;
    logic               emit_c;

    always_comb begin
        logic [VALUE_W-1:0] acc_new;
        logic [LEN_W-1:0]   len_inc;
        logic               done;
        acc_new    = accum_reg;
        len_inc    = len_reg + LEN_W'(1);
        done       = 1'b0;
        phase_next = phase_reg;
        accum_next = accum_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        status_c   = ST_OK;
        emit_c     = 1'b0;

        // The group of seven bits lands at the slot picked by the current length.
        for (int k = 0; k < VARINT_GROUPS; k++) begin
            if (len_reg == LEN_W'(k)) begin
                acc_new[k*GROUP_BITS +: GROUP_BITS] =
                    accum_reg[k*GROUP_BITS +: GROUP_BITS] | beat.index_byte[GROUP_BITS-1:0];
            end
        end

        if (beat.first_byte) begin
            left_next  = '0;
            seen_next  = '0;
            total_next = '0;
            if (beat.index_byte != INDICATOR_BYTE) begin
                emit_c   = 1'b1;
                status_c = ST_BAD_IND;
            end else begin
                phase_next = PH_COUNT;
                accum_next = '0;
                len_next   = '0;
                if (beat.last_byte) begin
                    emit_c   = 1'b1;
                    status_c = ST_TRUNC;
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            accum_next = acc_new;
            len_next   = len_inc;
            if (beat.index_byte[BYTE_W-1]) begin
                if (len_inc >= LEN_W'(MAX_VARINT_BYTES)) begin
                    emit_c   = 1'b1;
                    status_c = ST_LONG;
                end else if (beat.last_byte) begin
                    emit_c   = 1'b1;
                    status_c = ST_TRUNC;
                end
            end else begin
                accum_next = '0;
                len_next   = '0;
                case (phase_reg)
                    PH_COUNT: begin
                        left_next = acc_new;
                        if (acc_new == '0) begin
                            done = 1'b1;
                        end else begin
                            phase_next = PH_UNPAD;
                        end
                    end
                    PH_UNPAD: begin
                        phase_next = PH_UNCOMP;
                    end
                    PH_UNCOMP: begin
                        total_next = total_reg + TOTAL_W'(acc_new);
                        seen_next  = seen_reg + VALUE_W'(1);
                        left_next  = left_reg - VALUE_W'(1);
                        if (left_reg == VALUE_W'(1)) begin
                            done = 1'b1;
                        end else begin
                            phase_next = PH_UNPAD;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (done) begin
                    emit_c   = 1'b1;
                    status_c = ST_OK;
                end else if (beat.last_byte) begin
                    emit_c   = 1'b1;
                    status_c = ST_TRUNC;
                end
            end
        end

        if (emit_c) begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            accum_reg <= accum_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            seen_reg  <= seen_next;
            total_reg <= total_next;
        end
    end

    assign emit                      = step && emit_c;
    assign result.total_uncompressed = (status_c == ST_OK) ? total_next : '0;
    assign result.records_done       = seen_next;
    assign result.status             = status_c;

    a_emit_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> phase_reg == PH_IDLE)
        else $error("parser did not go idle after giving a result");

    a_phase_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg))
        else $error("parse phase moved without a byte");

    a_error_total_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && result.status != ST_OK |-> result.total_uncompressed == '0)
        else $error("error result carries a non-zero total");

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> len_reg < LEN_W'(MAX_VARINT_BYTES))
        else $error("varint length ran past its limit");

    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_UNCOMP |-> left_reg != '0)
        else $error("size being decoded with no records left");

endmodule
